// ===== rtl/sdd_pkg.sv =====
// Shared types for the double-by-single word divider.
// Holds the request codes and the controller-to-datapath command and status structs.
// No dependencies.
package sdd_pkg;

    localparam logic [1:0] REQ_SYMMETRIC = 2'd0;
    localparam logic [1:0] REQ_FLOORED   = 2'd1;
    localparam logic [1:0] REQ_UNSIGNED  = 2'd2;

    typedef struct packed {
        logic load;
        logic absolute;
        logic step;
        logic fix;
    } t_dp_cmd;

    typedef struct packed {
        logic dz;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/sdd_stream_if.sv =====
// Valid/ready channel interfaces for divider requests and responses.
// No dependencies.
interface sdd_req_if #(
    parameter int DATA_W = 32
);
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [DATA_W-1:0] dividend_high;
    logic [DATA_W-1:0] dividend_low;
    logic [DATA_W-1:0] divisor;

    modport source (output valid, req_type, dividend_high, dividend_low, divisor,
                    input ready);
    modport sink (input valid, req_type, dividend_high, dividend_low, divisor,
                  output ready);
endinterface

interface sdd_rsp_if #(
    parameter int DATA_W = 32
);
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
    logic              quotient_overflow;

    modport source (output valid, quotient, remainder, divide_by_zero, quotient_overflow,
                    input ready);
    modport sink (input valid, quotient, remainder, divide_by_zero, quotient_overflow,
                  output ready);
endinterface

// ===== rtl/signed_double_by_single_divider.sv =====
// A request beat is accepted only in idle; a zero divisor skips the divide loop and goes
// straight to the fix-up. A new request is taken only after the last one's result is in
// the response register; the restoring loop retires one dividend bit per cycle in a
// single subtractor.
// The response register holds a finished beat while the next request is taken.
// Reset is synchronous and active low; it clears the controller and the response valid.
module signed_double_by_single_divider
    import sdd_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sdd_req_if.sink   i_req,
    sdd_rsp_if.source o_rsp
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    sdd_ctrl #(
        .DATA_W (DATA_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sdd_datapath #(
        .DATA_W (DATA_W)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_req_type          (i_req.req_type),
        .i_dividend_high     (i_req.dividend_high),
        .i_dividend_low      (i_req.dividend_low),
        .i_divisor           (i_req.divisor),
        .o_valid             (o_rsp.valid),
        .i_ready             (o_rsp.ready),
        .o_quotient          (o_rsp.quotient),
        .o_remainder         (o_rsp.remainder),
        .o_divide_by_zero    (o_rsp.divide_by_zero),
        .o_quotient_overflow (o_rsp.quotient_overflow)
    );

endmodule

// ===== rtl/sdd_ctrl.sv =====
// Controller state machine of the divider: sequences load, sign removal,
// the bit-serial divide loop and the result fix-up. Depends on sdd_pkg.
module sdd_ctrl
    import sdd_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(2 * DATA_W);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(2 * DATA_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_DIV,
        S_FIX
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_ABS;
                end
            end
            S_ABS: begin
                if (i_sts.dz) begin
                    n_state = S_FIX;
                end else begin
                    n_state = S_DIV;
                    n_cnt   = CNT_MAX;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIX: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_req_ready    = (r_state == S_IDLE);
    assign o_cmd.load     = (r_state == S_IDLE) && i_req_valid;
    assign o_cmd.absolute = (r_state == S_ABS);
    assign o_cmd.step     = (r_state == S_DIV);
    assign o_cmd.fix      = (r_state == S_FIX) && i_sts.out_free;

`ifndef SYNTHESIS
    a_accept_goes_abs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> r_state == S_ABS)
        else $error("accepted beat did not start sign removal");

    a_abs_starts_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ABS && !i_sts.dz |=> r_state == S_DIV && r_cnt == CNT_MAX)
        else $error("divide loop not started with full count");

    a_loop_ends_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && r_cnt == '0 |=> r_state == S_FIX)
        else $error("divide loop did not end in fix-up");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.absolute, o_cmd.step, o_cmd.fix}))
        else $error("more than one datapath command at once");
`endif

endmodule

// ===== rtl/sdd_datapath.sv =====
// Datapath of the divider: operand registers, one restoring step per cycle,
// sign fix-up and the output register. Depends on sdd_pkg.
module sdd_datapath
    import sdd_pkg::*;
#(
    parameter int DATA_W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [1:0]        i_req_type,
    input  logic [DATA_W-1:0] i_dividend_high,
    input  logic [DATA_W-1:0] i_dividend_low,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_quotient,
    output logic [DATA_W-1:0] o_remainder,
    output logic              o_divide_by_zero,
    output logic              o_quotient_overflow
);

    localparam int W = DATA_W;

    logic [1:0]     r_mode;
    logic [2*W-1:0] r_num;
    logic [W-1:0]   r_rem;
    logic [W-1:0]   r_den;
    logic           r_num_neg;
    logic           r_den_neg;
    logic           r_dz;

    logic           r_o_valid;
    logic [W-1:0]   r_o_q;
    logic [W-1:0]   r_o_r;
    logic           r_o_dz;
    logic           r_o_ovf;

    logic [W-1:0]   n_trial;
    logic           n_qbit;
    logic [W-1:0]   n_q;
    logic [W-1:0]   n_r;
    logic           n_ovf;
    logic [W-1:0]   qlo;
    logic           diff_sign;

    // One restoring step: the carried-out top bit forces a subtract.
    always_comb begin
        n_trial = {r_rem[W-2:0], r_num[2*W-1]};
        n_qbit  = r_rem[W-1] || (n_trial >= r_den);
    end

    assign qlo       = r_num[W-1:0];
    assign diff_sign = r_num_neg ^ r_den_neg;

    always_comb begin
        n_q   = qlo;
        n_r   = r_rem;
        n_ovf = |r_num[2*W-1:W];
        if (r_dz) begin
            n_q   = '0;
            n_r   = '0;
            n_ovf = 1'b0;
        end else if (!r_mode[1]) begin
            if (!r_mode[0]) begin
                n_r = r_num_neg ? (~r_rem + 1'b1) : r_rem;
                n_q = diff_sign ? (~qlo + 1'b1) : qlo;
            end else if (diff_sign && (r_rem != '0)) begin
                // The magnitude grows by one, so the quotient is the complement.
                n_q   = ~qlo;
                n_ovf = (|r_num[2*W-1:W]) || (&qlo);
                n_r   = r_den_neg ? (r_rem - r_den) : (r_den - r_rem);
            end else begin
                n_q = diff_sign ? (~qlo + 1'b1) : qlo;
                n_r = r_den_neg ? (~r_rem + 1'b1) : r_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_req_type;
            r_num     <= {i_dividend_high, i_dividend_low};
            r_den     <= i_divisor;
            r_rem     <= '0;
            r_dz      <= (i_divisor == '0);
            r_num_neg <= !i_req_type[1] && i_dividend_high[W-1];
            r_den_neg <= !i_req_type[1] && i_divisor[W-1];
        end else if (i_cmd.absolute) begin
            if (r_num_neg) begin
                r_num <= ~r_num + 1'b1;
            end
            if (r_den_neg) begin
                r_den <= ~r_den + 1'b1;
            end
        end else if (i_cmd.step) begin
            r_rem <= n_qbit ? (n_trial - r_den) : n_trial;
            r_num <= {r_num[2*W-2:0], n_qbit};
        end
        if (i_cmd.fix) begin
            r_o_q   <= n_q;
            r_o_r   <= n_r;
            r_o_dz  <= r_dz;
            r_o_ovf <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.fix) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_sts.dz       = r_dz;
    assign o_sts.out_free = !r_o_valid || i_ready;

    assign o_valid             = r_o_valid;
    assign o_quotient          = r_o_q;
    assign o_remainder         = r_o_r;
    assign o_divide_by_zero    = r_o_dz;
    assign o_quotient_overflow = r_o_ovf;

endmodule
